@@ rtl/psr_pkg.sv @@
// ---------------------------------------------------------------------------
// psr_pkg
// Shared types and constants of the polyphase sinc resampler.
// ---------------------------------------------------------------------------
package psr_pkg;

    localparam int FRAC_BITS = 24;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int COEF_IDX_W = 14;
    localparam int STEP_W    = 28;
    localparam int POS_W     = 32;
    localparam int WEIGHT_W  = 44;
    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_COEF    = 2'd1,
        REQ_RESTART = 2'd2
    } req_code_t;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

    // Tag that travels with each tap through the weight and lane pipelines
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tap_ctl_t;

endpackage

@@ rtl/psr_if.sv @@
// ---------------------------------------------------------------------------
// psr_if
// Valid/ready channels of the resampler: requests, results, register writes.
// ---------------------------------------------------------------------------
interface psr_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             req_type;
    logic signed [psr_pkg::SAMPLE_W-1:0]    sample_left;
    logic signed [psr_pkg::SAMPLE_W-1:0]    sample_right;
    logic [psr_pkg::COEF_IDX_W-1:0]         coef_index;
    logic signed [psr_pkg::COEF_W-1:0]      coef_value;

    modport source (output valid, req_type, sample_left, sample_right, coef_index,
                    coef_value, input ready);
    modport sink (input valid, req_type, sample_left, sample_right, coef_index,
                  coef_value, output ready);
endinterface

interface psr_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [psr_pkg::SAMPLE_W-1:0]    out_left;
    logic signed [psr_pkg::SAMPLE_W-1:0]    out_right;
    logic                                   last;

    modport source (output valid, out_left, out_right, last, input ready);
    modport sink (input valid, out_left, out_right, last, output ready);
endinterface

interface psr_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [psr_pkg::CFG_IDX_W-1:0]          index;
    logic [psr_pkg::STEP_W-1:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/psr_coef.sv @@
// ---------------------------------------------------------------------------
// psr_coef
// Coefficient store with two read ports and the phase interpolation of
// the tap weight, three pipeline stages from address to weight.
// ---------------------------------------------------------------------------
module psr_coef #(
    parameter int STORE  = 8224,
    parameter int ADDR_W = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  we,
    input  logic [ADDR_W-1:0]                     waddr,
    input  logic signed [psr_pkg::COEF_W-1:0]     wdata,
    input  logic [ADDR_W-1:0]                     raddr0,
    input  logic [ADDR_W-1:0]                     raddr1,
    input  logic [psr_pkg::FRAC_BITS-1:0]         pf,
    input  psr_pkg::tap_ctl_t                     ctl_in,
    output logic signed [psr_pkg::WEIGHT_W-1:0]   weight,
    output psr_pkg::tap_ctl_t                     ctl_out
);

    logic signed [psr_pkg::COEF_W-1:0] mem [STORE];
    logic signed [psr_pkg::COEF_W-1:0] k0_reg;
    logic signed [psr_pkg::COEF_W-1:0] k1_reg;
    logic signed [psr_pkg::COEF_W-1:0] k0_s2_reg;
    logic signed [psr_pkg::WEIGHT_W-1:0] dprod_reg;
    logic signed [psr_pkg::WEIGHT_W-1:0] weight_reg;
    psr_pkg::tap_ctl_t ctl_s1_reg;
    psr_pkg::tap_ctl_t ctl_s2_reg;
    psr_pkg::tap_ctl_t ctl_s3_reg;

    logic signed [psr_pkg::COEF_W:0]       diff;
    logic signed [psr_pkg::FRAC_BITS:0]    pf_s;
    logic signed [psr_pkg::WEIGHT_W-1:0]   base;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        k0_reg <= mem[raddr0];
        k1_reg <= mem[raddr1];
    end

    assign diff = {k1_reg[psr_pkg::COEF_W-1], k1_reg} - {k0_reg[psr_pkg::COEF_W-1], k0_reg};
    assign pf_s = {1'b0, pf};
    assign base = {{(psr_pkg::WEIGHT_W - psr_pkg::COEF_W - psr_pkg::FRAC_BITS)
                    {k0_s2_reg[psr_pkg::COEF_W-1]}},
                   k0_s2_reg, {psr_pkg::FRAC_BITS{1'b0}}};

    always_ff @(posedge clk)
    begin
        dprod_reg  <= psr_pkg::WEIGHT_W'(diff * pf_s);
        k0_s2_reg  <= k0_reg;
        weight_reg <= base + dprod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s1_reg <= '0;
            ctl_s2_reg <= '0;
            ctl_s3_reg <= '0;
        end
        else
        begin
            ctl_s1_reg <= ctl_in;
            ctl_s2_reg <= ctl_s1_reg;
            ctl_s3_reg <= ctl_s2_reg;
        end
    end

    assign weight  = weight_reg;
    assign ctl_out = ctl_s3_reg;

endmodule

@@ rtl/psr_lane.sv @@
// ---------------------------------------------------------------------------
// psr_lane
// One channel lane: weight times sample, accumulate over the taps, then
// round half to even and saturate to 16 bits.
// ---------------------------------------------------------------------------
module psr_lane #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  psr_pkg::tap_ctl_t                     ctl,
    input  logic signed [psr_pkg::WEIGHT_W-1:0]   weight,
    input  logic signed [psr_pkg::SAMPLE_W-1:0]   sample,
    output logic signed [psr_pkg::SAMPLE_W-1:0]   result,
    output logic                                  done
);

    localparam int SH = COEF_FRAC_BITS + psr_pkg::FRAC_BITS;
    localparam int PROD_W = psr_pkg::WEIGHT_W + psr_pkg::SAMPLE_W;
    localparam logic signed [psr_pkg::ACC_W-1:0] SAT_HI = psr_pkg::ACC_W'(32767);
    localparam logic signed [psr_pkg::ACC_W-1:0] SAT_LO = -psr_pkg::ACC_W'(32768);

    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [psr_pkg::ACC_W-1:0]  acc_reg;
    psr_pkg::tap_ctl_t                 ctl_s4_reg;
    logic                              acc_last_reg;
    logic signed [psr_pkg::SAMPLE_W-1:0] result_reg;
    logic                              done_reg;

    logic signed [psr_pkg::ACC_W-1:0]  prod_ext;
    logic signed [psr_pkg::ACC_W-1:0]  q_floor;
    logic signed [psr_pkg::ACC_W-1:0]  q_round;
    logic [SH-1:0]                     rem;
    logic                              round_up;
    logic signed [psr_pkg::SAMPLE_W-1:0] sat;

    assign prod_ext = psr_pkg::ACC_W'(prod_reg);
    assign q_floor  = acc_reg >>> SH;
    assign rem      = acc_reg[SH-1:0];
    assign round_up = (rem > {1'b1, {(SH-1){1'b0}}})
                   || ((rem == {1'b1, {(SH-1){1'b0}}}) && q_floor[0]);
    assign q_round  = q_floor + psr_pkg::ACC_W'(round_up);

    always_comb
    begin
        if (q_round > SAT_HI)
        begin
            sat = 16'sd32767;
        end
        else if (q_round < SAT_LO)
        begin
            sat = -16'sd32768;
        end
        else
        begin
            sat = q_round[psr_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= weight * sample;
        if (ctl_s4_reg.valid)
        begin
            acc_reg <= ctl_s4_reg.first ? prod_ext : acc_reg + prod_ext;
        end
        if (acc_last_reg)
        begin
            result_reg <= sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s4_reg   <= '0;
            acc_last_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            ctl_s4_reg   <= ctl;
            acc_last_reg <= ctl_s4_reg.valid && ctl_s4_reg.last;
            done_reg     <= acc_last_reg;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

@@ rtl/polyphase_sinc_resampler.sv @@
// ---------------------------------------------------------------------------
// polyphase_sinc_resampler
// Polyphase FIR rate converter: history ring, sequencer, shared weight
// pipeline, left and right MAC lanes and the output merge register.
// ---------------------------------------------------------------------------
// Coefficient write, restart and bypass items are handled without leaving IDLE;
// a bypass result is shown in the output register on the next cycle.
// A sample frame causes at most MAX_OUTPUTS outputs, each computed one tap
// a cycle through the coefficient memory ports; no new request is taken
// until the frame is done.
// Reset clears ring, pointer, position and registers at once; the
// coefficient store is not cleared and must be written before use.
module polyphase_sinc_resampler #(
    parameter int TAPS           = 32,
    parameter int PHASES         = 256,
    parameter int MAX_OUTPUTS    = 8,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    psr_cfg_if.sink   cfg,
    psr_req_if.sink   req,
    psr_res_if.source res
);

    localparam int HALF   = TAPS / 2;
    localparam int PH_W   = $clog2(PHASES);
    localparam int IDX_W  = $clog2(TAPS);
    localparam int STORE  = (PHASES + 1) * TAPS;
    localparam int ADDR_W = $clog2(STORE);
    localparam int N_W    = $clog2(MAX_OUTPUTS + 1);
    localparam int FB     = psr_pkg::FRAC_BITS;
    localparam int PW     = psr_pkg::POS_W;
    localparam logic [PW-1:0] ONE_POS   = PW'(1) << FB;
    localparam logic [PW-1:0] HALF_POS  = PW'(HALF) << FB;
    localparam logic [PW-1:0] LIMIT_POS = PW'(HALF + 1) << FB;

    typedef enum logic [2:0] {IDLE, CHECK, RUN, DRAIN, EMIT} state_t;

    state_t                         state_reg;
    logic [psr_pkg::STEP_W-1:0]     step_reg;
    logic                           bypass_reg;
    logic [1:0]                     chan_reg;
    logic [31:0]                    ring_reg [TAPS];
    logic [IDX_W-1:0]               ptr_reg;
    logic [PW-1:0]                  pos_reg;
    logic [N_W-1:0]                 n_reg;
    logic [IDX_W-1:0]               tap_reg;
    logic [IDX_W-1:0]               ridx_reg;
    logic [ADDR_W-1:0]              addr0_reg;
    logic [ADDR_W-1:0]              addr1_reg;
    logic [FB-1:0]                  pf_reg;
    logic [31:0]                    frame_s1_reg;
    logic [31:0]                    frame_s2_reg;
    logic [31:0]                    frame_s3_reg;
    logic                           out_valid_reg;
    logic signed [psr_pkg::SAMPLE_W-1:0] out_left_reg;
    logic signed [psr_pkg::SAMPLE_W-1:0] out_right_reg;
    logic                           out_last_reg;

    logic                           mono;
    logic                           slot_free;
    logic                           req_fire;
    logic                           coef_we;
    logic                           out_load;
    logic [PH_W-1:0]                ph;
    logic [FB-1:0]                  pf;
    logic [ADDR_W-1:0]              row_base;
    logic [PW-1:0]                  pos_step;
    logic [PW-1:0]                  pos_rebased;
    logic                           more;
    psr_pkg::tap_ctl_t              ctl_issue;
    psr_pkg::tap_ctl_t              ctl_w;
    logic signed [psr_pkg::WEIGHT_W-1:0] weight;
    logic signed [psr_pkg::SAMPLE_W-1:0] res_left;
    logic signed [psr_pkg::SAMPLE_W-1:0] res_right;
    logic                           done_left;
    logic                           done_right;

    assign mono      = chan_reg == 2'd1;
    assign slot_free = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == IDLE) && slot_free;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign coef_we   = req_fire && (req.req_type == psr_pkg::REQ_COEF)
                    && (32'(req.coef_index) < 32'(STORE));
    // a new item enters the output register this cycle
    assign out_load  = (req_fire && (req.req_type == psr_pkg::REQ_SAMPLE) && bypass_reg)
                    || ((state_reg == EMIT) && slot_free);

    assign ph       = pos_reg[FB-1 -: PH_W];
    assign pf       = {pos_reg[FB-PH_W-1:0], {PH_W{1'b0}}};
    assign row_base = ADDR_W'(32'(ph) * 32'(TAPS));
    assign pos_step = pos_reg + PW'(step_reg);
    assign more     = (pos_step < LIMIT_POS) && (32'(n_reg) + 32'd1 < 32'(MAX_OUTPUTS));

    always_comb
    begin
        pos_rebased = ((state_reg == EMIT) ? pos_step : pos_reg) - ONE_POS;
        if (pos_rebased < HALF_POS)
        begin
            pos_rebased = HALF_POS;
        end
    end

    assign ctl_issue.valid = state_reg == RUN;
    assign ctl_issue.first = tap_reg == '0;
    assign ctl_issue.last  = tap_reg == IDX_W'(TAPS - 1);

    psr_coef #(
        .STORE  (STORE),
        .ADDR_W (ADDR_W)
    ) u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (coef_we),
        .waddr   (ADDR_W'(req.coef_index)),
        .wdata   (req.coef_value),
        .raddr0  (addr0_reg),
        .raddr1  (addr1_reg),
        .pf      (pf_reg),
        .ctl_in  (ctl_issue),
        .weight  (weight),
        .ctl_out (ctl_w)
    );

    psr_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_w),
        .weight (weight),
        .sample (frame_s3_reg[15:0]),
        .result (res_left),
        .done   (done_left)
    );

    psr_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_w),
        .weight (weight),
        .sample (frame_s3_reg[31:16]),
        .result (res_right),
        .done   (done_right)
    );

    // Frame delay line, aligned with the weight pipeline
    always_ff @(posedge clk)
    begin
        frame_s1_reg <= ring_reg[ridx_reg];
        frame_s2_reg <= frame_s1_reg;
        frame_s3_reg <= frame_s2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            step_reg      <= psr_pkg::STEP_W'(ONE_POS);
            bypass_reg    <= 1'b1;
            chan_reg      <= 2'd2;
            for (int i = 0; i < TAPS; i++)
            begin
                ring_reg[i] <= '0;
            end
            ptr_reg       <= '0;
            pos_reg       <= HALF_POS;
            n_reg         <= '0;
            tap_reg       <= '0;
            ridx_reg      <= '0;
            addr0_reg     <= '0;
            addr1_reg     <= '0;
            pf_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_left_reg  <= '0;
            out_right_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    psr_pkg::CFG_STEP:     step_reg   <= cfg.data;
                    psr_pkg::CFG_BYPASS:   bypass_reg <= cfg.data[0];
                    psr_pkg::CFG_CHANNELS: chan_reg   <= cfg.data[1:0];
                    default:               ;
                endcase
            end

            if (out_valid_reg && res.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (req_fire)
                    begin
                        case (req.req_type)
                            psr_pkg::REQ_SAMPLE:
                            begin
                                if (bypass_reg)
                                begin
                                    out_valid_reg <= 1'b1;
                                    out_left_reg  <= req.sample_left;
                                    out_right_reg <= mono ? '0 : req.sample_right;
                                    out_last_reg  <= 1'b1;
                                end
                                else
                                begin
                                    ring_reg[ptr_reg] <= {req.sample_right, req.sample_left};
                                    ptr_reg <= (ptr_reg == IDX_W'(TAPS - 1)) ? '0
                                             : ptr_reg + 1'b1;
                                    n_reg     <= '0;
                                    state_reg <= CHECK;
                                end
                            end
                            psr_pkg::REQ_RESTART:
                            begin
                                for (int i = 0; i < TAPS; i++)
                                begin
                                    ring_reg[i] <= '0;
                                end
                                ptr_reg <= '0;
                                pos_reg <= HALF_POS;
                            end
                            default: ;
                        endcase
                    end
                end
                CHECK:
                begin
                    if (pos_reg < LIMIT_POS)
                    begin
                        tap_reg   <= '0;
                        ridx_reg  <= ptr_reg;
                        addr0_reg <= row_base;
                        addr1_reg <= row_base + ADDR_W'(TAPS);
                        pf_reg    <= pf;
                        state_reg <= RUN;
                    end
                    else
                    begin
                        // no output due: rebase and finish
                        pos_reg   <= pos_rebased;
                        state_reg <= IDLE;
                    end
                end
                RUN:
                begin
                    tap_reg   <= tap_reg + 1'b1;
                    ridx_reg  <= (ridx_reg == IDX_W'(TAPS - 1)) ? '0 : ridx_reg + 1'b1;
                    addr0_reg <= addr0_reg + 1'b1;
                    addr1_reg <= addr1_reg + 1'b1;
                    if (ctl_issue.last)
                    begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN:
                begin
                    if (done_left)
                    begin
                        state_reg <= EMIT;
                    end
                end
                EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_left_reg  <= res_left;
                        out_right_reg <= mono ? '0 : res_right;
                        out_last_reg  <= !more;
                        n_reg         <= n_reg + 1'b1;
                        if (more)
                        begin
                            pos_reg   <= pos_step;
                            state_reg <= CHECK;
                        end
                        else
                        begin
                            pos_reg   <= pos_rebased;
                            state_reg <= IDLE;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_left  = out_left_reg;
    assign res.out_right = out_right_reg;
    assign res.last      = out_last_reg;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == IDLE))
        else $error("request taken outside idle");

    a_pos_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE) |-> (pos_reg >= HALF_POS))
        else $error("position below half window");

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_left == done_right)
        else $error("lanes out of step");

    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done_left |-> (state_reg == DRAIN))
        else $error("lane result outside drain");

endmodule
